FILE: rtl/bscu_pkg.sv
// Shared types, constants and helpers of the barometric compensation unit.
package bscu_pkg;

   localparam int DATA_W   = 32;
   localparam int UT_W     = 16;
   localparam int UP_W     = 19;
   localparam int TEMP_W   = 28;
   localparam int STAT_W   = 2;
   localparam int ADDR_W   = 5;
   localparam int Q_DEPTH  = 4;
   localparam int Q_PTR_W  = 2;
   localparam int Q_CNT_W  = 3;

   localparam logic [DATA_W-1:0] B6_OFFSET   = 32'd4000;
   localparam logic [DATA_W-1:0] X3_BIAS     = 32'd32768;
   localparam logic [DATA_W-1:0] P_SCALE     = 32'd50000;
   localparam logic [DATA_W-1:0] B7_HALF     = 32'h8000_0000;
   localparam logic [DATA_W-1:0] P_COEF_SQ   = 32'd3038;
   localparam logic [DATA_W-1:0] P_COEF_LIN  = 32'hFFFF_E343; // -7357
   localparam logic [DATA_W-1:0] P_COEF_OFS  = 32'd3791;

   localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_TEMP_DIV = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_PRES_DIV = 2'd2;

   typedef enum logic [2:0] {
      REG_AC1_AC2 = 3'd0,
      REG_AC3_AC4 = 3'd1,
      REG_AC5_AC6 = 3'd2,
      REG_B1_B2   = 3'd3,
      REG_MC_MD   = 3'd4,
      REG_OSS     = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [15:0] ac1;
      logic [15:0] ac2;
      logic [15:0] ac3;
      logic [15:0] ac4;
      logic [15:0] ac5;
      logic [15:0] ac6;
      logic [15:0] b1;
      logic [15:0] b2;
      logic [15:0] mc;
      logic [15:0] md;
      logic [1:0]  oss;
   } cfg_type;

   typedef struct packed {
      logic [DATA_W-1:0] x1;
      logic [UP_W-1:0]   up;
   } qentry_type;

   // sideband that rides along the dividers
   typedef struct packed {
      logic [DATA_W-1:0] x1;
      logic [UP_W-1:0]   up;
      logic [TEMP_W-1:0] temp;
      logic              neg;
      logic              post;
      logic              tz;
      logic              pz;
   } ctx_type;

   typedef struct packed {
      logic [TEMP_W-1:0] temp;
      logic [UP_W-1:0]   up;
      logic              tz;
   } side_type;

   function automatic logic [DATA_W-1:0] sx16(input logic [15:0] v);
      return {{(DATA_W-16){v[15]}}, v};
   endfunction

   function automatic logic [DATA_W-1:0] asr(input logic [DATA_W-1:0] v, input int n);
      return DATA_W'($signed(v) >>> n);
   endfunction

endpackage

FILE: rtl/bscu_if.sv
// Valid/ready channel interfaces for raw samples and compensated results.
interface bscu_req_if;
   logic                        valid;
   logic                        ready;
   logic [bscu_pkg::UT_W-1:0]   raw_temperature;
   logic [bscu_pkg::UP_W-1:0]   raw_pressure;
   modport source (output valid, output raw_temperature, output raw_pressure, input ready);
   modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface bscu_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [bscu_pkg::TEMP_W-1:0] temperature_tenths;
   logic signed [bscu_pkg::DATA_W-1:0] pressure_reading;
   logic [bscu_pkg::STAT_W-1:0]        status;
   modport source (output valid, output temperature_tenths, output pressure_reading,
                   output status, input ready);
   modport sink   (input valid, input temperature_tenths, input pressure_reading,
                   input status, output ready);
endinterface

FILE: rtl/baro_sensor_compensation_unit.sv
// Barometric sensor compensation unit: takes one raw temperature/pressure transaction
// per clock while its queue has room and returns the compensated temperature (tenths
// of a degree), pressure (Pa) and a divisor status for each, in order. A result
// passes a sign stage, two 32-stage pipelined dividers (temperature divisor X1+MD,
// pressure divisor B4), nine multiplier and adder stages and the output register;
// sustained throughput is one transaction per cycle while the result side takes them.
// A four-entry queue decouples sample intake from the compensation pipeline,
// and the pipeline stalls as a whole only while a result waits at the output.
// Calibration words and OSS are written over APB; the user must write them only
// while the unit is idle, since the block itself does not enforce this.
module baro_sensor_compensation_unit (
   input  logic                          clock,
   input  logic                          reset,
   bscu_req_if.sink                      req,
   bscu_rsp_if.source                    rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bscu_pkg::ADDR_W-1:0]   paddr,
   input  logic [bscu_pkg::DATA_W-1:0]   pwdata,
   output logic [bscu_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   bscu_pkg::cfg_type    cfg;
   bscu_pkg::qentry_type push_data, head;
   logic                 push, pop, full, not_empty;

   bscu_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bscu_front u_front (
      .req       (req),
      .cfg       (cfg),
      .q_full    (full),
      .push      (push),
      .push_data (push_data)
   );

   bscu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head      (head)
   );

   bscu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .q_not_empty (not_empty),
      .q_head      (head),
      .q_pop       (pop),
      .rsp         (rsp)
   );

endmodule

FILE: rtl/bscu_regs.sv
// APB calibration and oversampling registers.
module bscu_regs (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bscu_pkg::ADDR_W-1:0]   paddr,
   input  logic [bscu_pkg::DATA_W-1:0]   pwdata,
   output logic [bscu_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output bscu_pkg::cfg_type             cfg
);
   logic [31:0] ac12_ff, ac34_ff, ac56_ff, b12_ff, mcmd_ff;
   logic [1:0]  oss_ff;
   logic        wr_en;
   logic [2:0]  idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         ac12_ff <= '0;
         ac34_ff <= '0;
         ac56_ff <= '0;
         b12_ff  <= '0;
         mcmd_ff <= '0;
         oss_ff  <= '0;
      end else if (wr_en) begin
         unique case (idx)
            bscu_pkg::REG_AC1_AC2: ac12_ff <= pwdata;
            bscu_pkg::REG_AC3_AC4: ac34_ff <= pwdata;
            bscu_pkg::REG_AC5_AC6: ac56_ff <= pwdata;
            bscu_pkg::REG_B1_B2:   b12_ff  <= pwdata;
            bscu_pkg::REG_MC_MD:   mcmd_ff <= pwdata;
            bscu_pkg::REG_OSS:     oss_ff  <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         bscu_pkg::REG_AC1_AC2: prdata = ac12_ff;
         bscu_pkg::REG_AC3_AC4: prdata = ac34_ff;
         bscu_pkg::REG_AC5_AC6: prdata = ac56_ff;
         bscu_pkg::REG_B1_B2:   prdata = b12_ff;
         bscu_pkg::REG_MC_MD:   prdata = mcmd_ff;
         bscu_pkg::REG_OSS:     prdata = {30'd0, oss_ff};
         default:               prdata = '0;
      endcase
   end

   assign cfg.ac1 = ac12_ff[31:16];
   assign cfg.ac2 = ac12_ff[15:0];
   assign cfg.ac3 = ac34_ff[31:16];
   assign cfg.ac4 = ac34_ff[15:0];
   assign cfg.ac5 = ac56_ff[31:16];
   assign cfg.ac6 = ac56_ff[15:0];
   assign cfg.b1  = b12_ff[31:16];
   assign cfg.b2  = b12_ff[15:0];
   assign cfg.mc  = mcmd_ff[31:16];
   assign cfg.md  = mcmd_ff[15:0];
   assign cfg.oss = oss_ff;

endmodule

FILE: rtl/bscu_front.sv
// Front end: accept raw samples and form the first temperature term.
module bscu_front (
   bscu_req_if.sink                 req,
   input  bscu_pkg::cfg_type        cfg,
   input  logic                     q_full,
   output logic                     push,
   output bscu_pkg::qentry_type     push_data
);
   logic [bscu_pkg::DATA_W-1:0] diff;
   logic [bscu_pkg::DATA_W-1:0] prod;

   assign req.ready = ~q_full;
   assign push      = req.valid & ~q_full;

   // (UT - AC6) * AC5, wrapping at 32 bits
   assign diff = {16'd0, req.raw_temperature} - {16'd0, cfg.ac6};
   assign prod = diff * {16'd0, cfg.ac5};

   assign push_data.x1 = bscu_pkg::asr(prod, 15);
   assign push_data.up = req.raw_pressure;

endmodule

FILE: rtl/bscu_queue.sv
// Short queue between the front end and the compensation pipeline.
module bscu_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bscu_pkg::qentry_type  push_data,
   input  logic                  pop,
   output logic                  full,
   output logic                  not_empty,
   output bscu_pkg::qentry_type  head
);
   bscu_pkg::qentry_type                mem_ff [bscu_pkg::Q_DEPTH];
   logic [bscu_pkg::Q_PTR_W-1:0]        wr_ff, rd_ff;
   logic [bscu_pkg::Q_CNT_W-1:0]        count_ff;
   logic                                do_push, do_pop;

   assign full      = count_ff == bscu_pkg::Q_CNT_W'(bscu_pkg::Q_DEPTH);
   assign not_empty = count_ff != '0;
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;
   assign head      = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop)  rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + Q_CNT_W_ONE(do_push) - Q_CNT_W_ONE(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

   function automatic logic [bscu_pkg::Q_CNT_W-1:0] Q_CNT_W_ONE(input logic b);
      return {{(bscu_pkg::Q_CNT_W-1){1'b0}}, b};
   endfunction

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bscu_pkg::Q_CNT_W'(bscu_pkg::Q_DEPTH))
      else $error("queue count beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full && !do_pop |=> full)
      else $error("queue lost an entry while full");

endmodule

FILE: rtl/bscu_div.sv
// Pipelined 32-bit unsigned divider, one quotient bit per stage.
module bscu_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  logic [bscu_pkg::DATA_W-1:0]   dividend,
   input  logic [bscu_pkg::DATA_W-1:0]   divisor,
   input  bscu_pkg::ctx_type             in_ctx,
   output logic                          out_valid,
   output logic [bscu_pkg::DATA_W-1:0]   quotient,
   output bscu_pkg::ctx_type             out_ctx
);
   localparam int W = bscu_pkg::DATA_W;

   logic [W-1:0]      valid_ff;
   logic [W-1:0]      rem_ff [W];
   logic [W-1:0]      quo_ff [W];
   logic [W-1:0]      dvs_ff [W];
   bscu_pkg::ctx_type ctx_ff [W];

   for (genvar i = 0; i < W; i++) begin : g_stage
      logic [W-1:0]      r_src, q_src, d_src;
      bscu_pkg::ctx_type c_src;
      logic              v_src;
      logic [W:0]        trial, diff;
      logic              ge;

      if (i == 0) begin : g_first
         assign r_src = '0;
         assign q_src = dividend;
         assign d_src = divisor;
         assign c_src = in_ctx;
         assign v_src = in_valid;
      end else begin : g_next
         assign r_src = rem_ff[i-1];
         assign q_src = quo_ff[i-1];
         assign d_src = dvs_ff[i-1];
         assign c_src = ctx_ff[i-1];
         assign v_src = valid_ff[i-1];
      end

      assign trial = {r_src, q_src[W-1]};
      assign diff  = trial - {1'b0, d_src};
      assign ge    = trial >= {1'b0, d_src};

      always_ff @(posedge clock) begin
         if (reset) valid_ff[i] <= 1'b0;
         else if (enable) valid_ff[i] <= v_src;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i] <= ge ? diff[W-1:0] : trial[W-1:0];
            quo_ff[i] <= {q_src[W-2:0], ge};
            dvs_ff[i] <= d_src;
            ctx_ff[i] <= c_src;
         end
      end
   end

   assign out_valid = valid_ff[W-1];
   assign quotient  = quo_ff[W-1];
   assign out_ctx   = ctx_ff[W-1];

endmodule

FILE: rtl/bscu_back.sv
// Back end: temperature and pressure compensation pipeline with output register.
module bscu_back (
   input  logic                  clock,
   input  logic                  reset,
   input  bscu_pkg::cfg_type     cfg,
   input  logic                  q_not_empty,
   input  bscu_pkg::qentry_type  q_head,
   output logic                  q_pop,
   bscu_rsp_if.source            rsp
);
   localparam int W = bscu_pkg::DATA_W;

   logic adv;

   // stage 0: temperature divisor and operand signs
   logic              s0_valid_ff;
   logic [W-1:0]      s0_ma_ff, s0_mb_ff;
   bscu_pkg::ctx_type s0_ctx_ff;
   logic [W-1:0]      denom, num1;

   logic              d1_valid;
   logic [W-1:0]      d1_q;
   bscu_pkg::ctx_type d1_ctx;

   logic               s1_valid_ff;
   logic [W-1:0]       s1_b6_ff;
   bscu_pkg::side_type s1_side_ff;
   logic [W-1:0]       x2t, b5, t8;

   logic               s2_valid_ff;
   logic [W-1:0]       s2_sqr_ff, s2_ac2b6_ff, s2_ac3b6_ff;
   bscu_pkg::side_type s2_side_ff;
   logic [W-1:0]       sq;

   logic               s3_valid_ff;
   logic [W-1:0]       s3_b2sq_ff, s3_b1sq_ff, s3_ac2b6_ff, s3_ac3b6_ff;
   bscu_pkg::side_type s3_side_ff;
   logic [W-1:0]       x3a, v3, x3s, v3r;

   logic               s4_valid_ff;
   logic [W-1:0]       s4_b3_ff, s4_x3_ff;
   bscu_pkg::side_type s4_side_ff;

   logic               s5_valid_ff;
   logic [W-1:0]       s5_b4_ff, s5_b7_ff;
   bscu_pkg::side_type s5_side_ff;
   logic [W-1:0]       b4_prod;

   logic              s6_valid_ff;
   logic [W-1:0]      s6_num_ff, s6_b4_ff;
   bscu_pkg::ctx_type s6_ctx_ff;

   logic              d2_valid;
   logic [W-1:0]      d2_q;
   bscu_pkg::ctx_type d2_ctx;

   logic              s7_valid_ff;
   logic [W-1:0]      s7_p_ff;
   bscu_pkg::ctx_type s7_ctx_ff;
   logic [W-1:0]      p8;

   logic              s8_valid_ff;
   logic [W-1:0]      s8_tt_ff, s8_m2_ff, s8_p_ff;
   bscu_pkg::ctx_type s8_ctx_ff;

   logic              s9_valid_ff;
   logic [W-1:0]      s9_m1_ff, s9_m2_ff, s9_p_ff;
   bscu_pkg::ctx_type s9_ctx_ff;
   logic [W-1:0]      corr, p_fin;

   logic                          out_valid_ff;
   logic [bscu_pkg::TEMP_W-1:0]   out_temp_ff;
   logic [W-1:0]                  out_pres_ff;
   logic [bscu_pkg::STAT_W-1:0]   out_stat_ff;

   // advance the whole pipeline unless a finished result is stuck at the output
   assign adv   = ~out_valid_ff | rsp.ready;
   assign q_pop = adv & q_not_empty;

   assign denom = q_head.x1 + bscu_pkg::sx16(cfg.md);
   assign num1  = {{5{cfg.mc[15]}}, cfg.mc, 11'd0};

   always_ff @(posedge clock) begin
      if (reset) s0_valid_ff <= 1'b0;
      else if (adv) s0_valid_ff <= q_pop;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ma_ff       <= num1[W-1] ? W'(0) - num1 : num1;
         s0_mb_ff       <= denom[W-1] ? W'(0) - denom : denom;
         s0_ctx_ff.x1   <= q_head.x1;
         s0_ctx_ff.up   <= q_head.up;
         s0_ctx_ff.temp <= '0;
         s0_ctx_ff.neg  <= num1[W-1] ^ denom[W-1];
         s0_ctx_ff.post <= 1'b0;
         s0_ctx_ff.tz   <= denom == '0;
         s0_ctx_ff.pz   <= 1'b0;
      end
   end

   bscu_div u_div_temp (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (s0_valid_ff),
      .dividend  (s0_ma_ff),
      .divisor   (s0_mb_ff),
      .in_ctx    (s0_ctx_ff),
      .out_valid (d1_valid),
      .quotient  (d1_q),
      .out_ctx   (d1_ctx)
   );

   // stage 1: B5, temperature, B6
   assign x2t = d1_ctx.neg ? W'(0) - d1_q : d1_q;
   assign b5  = d1_ctx.x1 + x2t;
   assign t8  = bscu_pkg::asr(b5 + W'(8), 4);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
         s9_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= d1_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= d2_valid;
         s8_valid_ff <= s7_valid_ff;
         s9_valid_ff <= s8_valid_ff;
         out_valid_ff <= s9_valid_ff;
      end
   end

   assign sq  = bscu_pkg::asr(s2_sqr_ff, 12);
   assign x3a = bscu_pkg::asr(s3_b2sq_ff, 11) + bscu_pkg::asr(s3_ac2b6_ff, 11);
   assign v3  = ((bscu_pkg::sx16(cfg.ac1) << 2) + x3a) << cfg.oss;
   assign v3r = v3 + W'(2);
   assign x3s = bscu_pkg::asr(s3_ac3b6_ff, 13) + bscu_pkg::asr(s3_b1sq_ff, 16) + W'(2);
   assign b4_prod = {16'd0, cfg.ac4} * (s4_x3_ff + bscu_pkg::X3_BIAS);

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_b6_ff        <= b5 - bscu_pkg::B6_OFFSET;
         s1_side_ff.temp <= t8[bscu_pkg::TEMP_W-1:0];
         s1_side_ff.up   <= d1_ctx.up;
         s1_side_ff.tz   <= d1_ctx.tz;

         s2_sqr_ff   <= s1_b6_ff * s1_b6_ff;
         s2_ac2b6_ff <= bscu_pkg::sx16(cfg.ac2) * s1_b6_ff;
         s2_ac3b6_ff <= bscu_pkg::sx16(cfg.ac3) * s1_b6_ff;
         s2_side_ff  <= s1_side_ff;

         s3_b2sq_ff  <= bscu_pkg::sx16(cfg.b2) * sq;
         s3_b1sq_ff  <= bscu_pkg::sx16(cfg.b1) * sq;
         s3_ac2b6_ff <= s2_ac2b6_ff;
         s3_ac3b6_ff <= s2_ac3b6_ff;
         s3_side_ff  <= s2_side_ff;

         // B3: add 2 then divide by 4 toward zero
         s4_b3_ff   <= v3r[W-1] ? W'(0) - ((W'(0) - v3r) >> 2) : v3r >> 2;
         s4_x3_ff   <= bscu_pkg::asr(x3s, 2);
         s4_side_ff <= s3_side_ff;

         s5_b4_ff   <= b4_prod >> 15;
         s5_b7_ff   <= ({13'd0, s4_side_ff.up} - s4_b3_ff) * (bscu_pkg::P_SCALE >> cfg.oss);
         s5_side_ff <= s4_side_ff;

         s6_b4_ff       <= s5_b4_ff;
         s6_num_ff      <= (s5_b7_ff < bscu_pkg::B7_HALF) ? s5_b7_ff << 1 : s5_b7_ff;
         s6_ctx_ff.x1   <= '0;
         s6_ctx_ff.up   <= s5_side_ff.up;
         s6_ctx_ff.temp <= s5_side_ff.temp;
         s6_ctx_ff.neg  <= 1'b0;
         s6_ctx_ff.post <= s5_b7_ff >= bscu_pkg::B7_HALF;
         s6_ctx_ff.tz   <= s5_side_ff.tz;
         s6_ctx_ff.pz   <= s5_b4_ff == '0;
      end
   end

   bscu_div u_div_pres (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (s6_valid_ff),
      .dividend  (s6_num_ff),
      .divisor   (s6_b4_ff),
      .in_ctx    (s6_ctx_ff),
      .out_valid (d2_valid),
      .quotient  (d2_q),
      .out_ctx   (d2_ctx)
   );

   assign p8    = bscu_pkg::asr(s7_p_ff, 8);
   assign corr  = bscu_pkg::asr(bscu_pkg::asr(s9_m1_ff, 16) + bscu_pkg::asr(s9_m2_ff, 16)
                                + bscu_pkg::P_COEF_OFS, 4);
   assign p_fin = s9_p_ff + corr;

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_p_ff   <= d2_ctx.post ? d2_q << 1 : d2_q;
         s7_ctx_ff <= d2_ctx;

         s8_tt_ff  <= p8 * p8;
         s8_m2_ff  <= bscu_pkg::P_COEF_LIN * s7_p_ff;
         s8_p_ff   <= s7_p_ff;
         s8_ctx_ff <= s7_ctx_ff;

         s9_m1_ff  <= s8_tt_ff * bscu_pkg::P_COEF_SQ;
         s9_m2_ff  <= s8_m2_ff;
         s9_p_ff   <= s8_p_ff;
         s9_ctx_ff <= s8_ctx_ff;

         priority if (s9_ctx_ff.tz) begin
            out_temp_ff <= '0;
            out_pres_ff <= '0;
            out_stat_ff <= bscu_pkg::STATUS_TEMP_DIV;
         end else if (s9_ctx_ff.pz) begin
            out_temp_ff <= s9_ctx_ff.temp;
            out_pres_ff <= '0;
            out_stat_ff <= bscu_pkg::STATUS_PRES_DIV;
         end else begin
            out_temp_ff <= s9_ctx_ff.temp;
            out_pres_ff <= p_fin;
            out_stat_ff <= bscu_pkg::STATUS_OK;
         end
      end
   end

   assign rsp.valid              = out_valid_ff;
   assign rsp.temperature_tenths = out_temp_ff;
   assign rsp.pressure_reading   = out_pres_ff;
   assign rsp.status             = out_stat_ff;

   a_temp_div_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_stat_ff == bscu_pkg::STATUS_TEMP_DIV
         |-> out_temp_ff == '0 && out_pres_ff == '0)
      else $error("temperature divisor fault carries nonzero result");
   a_pres_div_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_stat_ff == bscu_pkg::STATUS_PRES_DIV |-> out_pres_ff == '0)
      else $error("pressure divisor fault carries nonzero pressure");
   a_pop_only_adv: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> adv && q_not_empty)
      else $error("queue popped while pipeline stalled");

endmodule

FILE: tb/sv/bscu_result_checker.sv
// Passive checker: tracks calibration writes, predicts each compensated reading and compares.
module bscu_result_checker
   import bscu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   bscu_req_if                 req,
   bscu_rsp_if                 rsp,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   input  logic                pready,
   output int                  fail_count,
   output int                  pending
);

   typedef struct {
      logic [TEMP_W-1:0] temp;
      logic [DATA_W-1:0] press;
      logic [STAT_W-1:0] status;
   } reading_type;

   logic [31:0] cal_ac12, cal_ac34, cal_ac56, cal_b12, cal_mcmd;
   logic [1:0]  cal_oss;
   reading_type readings_due[$];

   function automatic logic [31:0] shr_s(input logic [31:0] v, input int n);
      logic [31:0] r;
      r = $signed(v) >>> n;
      return r;
   endfunction

   function automatic logic [31:0] sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   // signed division, truncating toward zero
   function automatic logic [31:0] quot_trunc(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] ma, mb, q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q  = ma / mb;
      return (a[31] ^ b[31]) ? -q : q;
   endfunction

   function automatic reading_type compensate(input logic [15:0] ut, input logic [18:0] up);
      reading_type r;
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] x1, x2, x3, denom, b5, b6, b3, b4, b7, p, sq, t;
      ac1 = sext16(cal_ac12[31:16]);
      ac2 = sext16(cal_ac12[15:0]);
      ac3 = sext16(cal_ac34[31:16]);
      ac4 = {16'd0, cal_ac34[15:0]};
      ac5 = {16'd0, cal_ac56[31:16]};
      ac6 = {16'd0, cal_ac56[15:0]};
      b1  = sext16(cal_b12[31:16]);
      b2  = sext16(cal_b12[15:0]);
      mc  = sext16(cal_mcmd[31:16]);
      md  = sext16(cal_mcmd[15:0]);
      r.temp = '0;
      r.press = '0;
      r.status = STATUS_OK;
      x1 = shr_s(({16'd0, ut} - ac6) * ac5, 15);
      denom = x1 + md;
      if (denom == 32'd0) begin
         r.status = STATUS_TEMP_DIV;
         return r;
      end
      x2 = quot_trunc(mc << 11, denom);
      b5 = x1 + x2;
      t = shr_s(b5 + 32'd8, 4);
      r.temp = t[TEMP_W-1:0];
      b6 = b5 - B6_OFFSET;
      sq = shr_s(b6 * b6, 12);
      x1 = shr_s(b2 * sq, 11);
      x2 = shr_s(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = quot_trunc(((ac1 * 32'd4 + x3) << cal_oss) + 32'd2, 32'd4);
      x1 = shr_s(ac3 * b6, 13);
      x2 = shr_s(b1 * sq, 16);
      x3 = shr_s(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + X3_BIAS)) >> 15;
      if (b4 == 32'd0) begin
         r.status = STATUS_PRES_DIV;
         return r;
      end
      b7 = ({13'd0, up} - b3) * (P_SCALE >> cal_oss);
      if (b7 < B7_HALF) p = (b7 * 32'd2) / b4;
      else p = (b7 / b4) * 32'd2;
      x1 = shr_s(p, 8);
      x1 = x1 * x1;
      x1 = shr_s(x1 * P_COEF_SQ, 16);
      x2 = shr_s(P_COEF_LIN * p, 16);
      r.press = p + shr_s(x1 + x2 + P_COEF_OFS, 4);
      return r;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         cal_ac12 <= '0; cal_ac34 <= '0; cal_ac56 <= '0;
         cal_b12  <= '0; cal_mcmd <= '0; cal_oss  <= '0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[4:2]))
               REG_AC1_AC2: cal_ac12 <= pwdata;
               REG_AC3_AC4: cal_ac34 <= pwdata;
               REG_AC5_AC6: cal_ac56 <= pwdata;
               REG_B1_B2:   cal_b12  <= pwdata;
               REG_MC_MD:   cal_mcmd <= pwdata;
               REG_OSS:     cal_oss  <= pwdata[1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            readings_due.push_back(compensate(req.raw_temperature, req.raw_pressure));
         if (rsp.valid && rsp.ready) begin
            if (readings_due.size() == 0) begin
               report("unexpected transaction, status", 32'(rsp.status), 32'd0);
            end else begin
               want = readings_due.pop_front();
               if (rsp.status !== want.status)
                  report("status", 32'(rsp.status), 32'(want.status));
               if (rsp.temperature_tenths !== want.temp)
                  report("temperature_tenths", 32'(rsp.temperature_tenths), 32'(want.temp));
               if (rsp.pressure_reading !== want.press)
                  report("pressure_reading", rsp.pressure_reading, want.press);
            end
         end
      end
      pending <= readings_due.size();
   end

endmodule

FILE: tb/sv/baro_sensor_compensation_unit_tb.sv
// Top of the compensation unit testbench: clock, reset, stimulus, calibration writes, verdict.
module baro_sensor_compensation_unit_tb;
   import bscu_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;
   int                fail_count, pending;
   int                quiet_cycles = 0;
   bit                calm = 1'b0;
   bit                want_long_hold = 1'b0;

   bscu_req_if req ();
   bscu_rsp_if rsp ();

   baro_sensor_compensation_unit u_top (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   bscu_result_checker u_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready), .fail_count(fail_count), .pending(pending)
   );

   always #10 clock = ~clock;

   // watchdog: runs out only when nothing moves for a long time
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || psel || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 3000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int hold_left, burst_left;
      bit long_done, nxt;
      hold_left = 0;
      burst_left = 0;
      long_done = 1'b0;
      rsp.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (want_long_hold && !long_done) begin
            long_done = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            nxt = 1'b0;
         end else if (burst_left > 0) begin
            burst_left--;
            nxt = 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(1, 17) - 1;
            nxt = 1'b0;
         end else begin
            nxt = 1'b1;
         end
         rsp.ready <= nxt;
      end
   end

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_calibration(input logic [31:0] w_ac12, input logic [31:0] w_ac34,
                                   input logic [31:0] w_ac56, input logic [31:0] w_b12,
                                   input logic [31:0] w_mcmd, input logic [1:0] oss);
      wait_drained();
      csr_write(REG_AC1_AC2, w_ac12);
      csr_write(REG_AC3_AC4, w_ac34);
      csr_write(REG_AC5_AC6, w_ac56);
      csr_write(REG_B1_B2, w_b12);
      csr_write(REG_MC_MD, w_mcmd);
      csr_write(REG_OSS, {30'd0, oss});
   endtask

   // datasheet-like calibration, optionally nudged
   task automatic load_typical(input logic [1:0] oss, input bit nudge);
      logic [15:0] d;
      d = nudge ? 16'($urandom_range(0, 63)) : 16'd0;
      load_calibration({16'd408 + d, -16'sd72}, {-16'sd14383, 16'd32741 - d},
                       {16'd32757, 16'd23153 + d}, {16'd6190, 16'd4 + d},
                       {-16'sd8711, 16'd2868 + d}, oss);
   endtask

   task automatic send_sample(input logic [15:0] ut, input logic [18:0] up);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.raw_temperature <= ut;
      req.raw_pressure <= up;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random();
      if ($urandom_range(0, 9) < 7)
         send_sample(16'($urandom_range(20000, 36000)), 19'($urandom_range(15000, 90000)));
      else
         send_sample(16'($urandom), 19'($urandom));
   endtask

   initial begin
      req.valid <= 1'b0;
      req.raw_temperature <= '0;
      req.raw_pressure <= '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset calibration: temperature divisor is zero
      send_sample(16'd27898, 19'd23843);
      send_sample(16'hFFFF, 19'h7FFFF);
      req.valid <= 1'b0;

      load_typical(2'd0, 1'b0);
      send_sample(16'd27898, 19'd23843);
      send_sample(16'd0, 19'd0);
      send_sample(16'hFFFF, 19'h7FFFF);
      send_sample(16'd0, 19'h7FFFF);
      send_sample(16'hFFFF, 19'd0);
      for (int m = 1; m < 4; m++) begin
         req.valid <= 1'b0;
         load_typical(2'(m), 1'b0);
         send_sample(16'd27898, 19'd23843 << m);
         send_sample(16'hFFFF, 19'h7FFFF);
         send_sample(16'd0, 19'd0);
      end
      req.valid <= 1'b0;
      // AC4 zero: pressure divisor is zero
      load_calibration({16'd408, -16'sd72}, {-16'sd14383, 16'd0}, {16'd32757, 16'd23153},
                       {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 2'd1);
      send_sample(16'd27898, 19'd23843);
      send_sample(16'd0, 19'h7FFFF);
      req.valid <= 1'b0;
      load_calibration(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
      send_sample(16'd0, 19'd0);
      send_sample(16'hFFFF, 19'h7FFFF);
      req.valid <= 1'b0;
      load_calibration(32'h8000_8000, 32'h8000_0001, 32'h0001_8000,
                       32'h8000_8000, 32'h8000_7FFF, 2'd2);
      send_sample(16'h8000, 19'h40000);
      send_sample(16'h7FFF, 19'h3FFFF);

      for (int ph = 0; ph < 10; ph++) begin
         req.valid <= 1'b0;
         case (ph)
            0, 1, 2, 3: load_typical(2'(ph), ph[0]);
            4: load_calibration(32'($urandom), 32'($urandom), 32'($urandom),
                                32'($urandom), 32'($urandom), 2'($urandom));
            5: load_calibration({16'd408, 16'($urandom)}, {16'($urandom), 16'($urandom)},
                                32'($urandom), 32'($urandom), {16'($urandom), 16'd0}, 2'd3);
            6: load_calibration(32'd0, 32'($urandom), {16'd0, 16'($urandom)},
                                32'($urandom), {16'($urandom), 16'd0}, 2'd2);
            7: load_calibration(32'($urandom), {16'($urandom), 16'd0}, 32'($urandom),
                                32'($urandom), 32'($urandom), 2'd1);
            default: load_typical(2'($urandom), 1'b1);
         endcase
         if (ph == 9) calm = 1'b1;
         if (ph == 1) want_long_hold = 1'b1;
         for (int k = 0; k < 110; k++) begin
            if (ph == 2 && k == 55) begin
               req.valid <= 1'b0;
               wait_drained();
            end
            send_random();
         end
      end
      req.valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
